// ===== rtl/pcvd_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the cell voltage decoder.
package pcvd_pkg;

   // Packet error code: CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
   localparam logic [7:0] PEC_POLY = 8'h07;
   localparam logic [7:0] PEC_INIT = 8'h41;

   // Frame lengths in data bytes
   localparam int         FRAME_BYTES_MAX = 18;
   localparam logic [4:0] LEN_TEN         = 5'd15;
   localparam logic [4:0] LEN_FULL        = 5'd18;

   // Cells per frame in ten-cell mode
   localparam logic [3:0] CELLS_TEN = 4'd10;

   // Frame store: two banks, one filling while the other drains
   localparam int RAM_DEPTH  = 2 * FRAME_BYTES_MAX;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

   // Defaults for top-level parameters
   localparam int MAX_CHIPS_DEF      = 16;
   localparam int CELLS_PER_CHIP_DEF = 12;

   // Control register port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEN_CELL_MODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_IN_USE  = 4'd1;
   localparam logic [3:0]             CELLS_IN_USE_RST  = 4'd12;

   // Per-cell control carried alongside a frame store read
   typedef struct packed {
      logic [3:0] chip;
      logic [3:0] cell_no;
      logic       odd;
      logic       ok;
      logic       mv_en;
      logic       last;
   } cell_meta_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ PEC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/pcvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcvd_ram
   import pcvd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pec_checked_cell_voltage_decoder.sv =====
// Top level: PEC-checked readback byte decoder producing per-cell voltage words.
// Throughput: one readback byte per cycle unless req_stall; a cell word per cycle while draining and not rsp_stall.
// Path: a PEC byte starts the emitter; each word is read from RAM, then registered at the output.
// A byte at the PEC position stalls only while the previous frame's 10 or CELLS_PER_CHIP cell words still drain.
// Frame store is two RAM copies (two read ports), banked so a frame fills during a drain.
// Reset (synchronous): counts, running PEC, chip index, control registers, valids; RAM is not cleared.
module pec_checked_cell_voltage_decoder
   import pcvd_pkg::*;
#(
   parameter int MAX_CHIPS      = MAX_CHIPS_DEF,
   parameter int CELLS_PER_CHIP = CELLS_PER_CHIP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // readback byte words
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_start_of_readback,
   // cell words
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_chip_index,
   output logic [3:0]             rsp_cell_index,
   output logic [11:0]            rsp_raw_code,
   output logic signed [13:0]     rsp_millivolts,
   output logic                   rsp_pec_ok,
   output logic                   rsp_last,
   // control registers
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [3:0] CELLS_FULL = 4'(CELLS_PER_CHIP);
   localparam logic [5:0] BANK_OFS   = 6'(FRAME_BYTES_MAX);

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   logic       ten_cell_mode_ff, ten_cell_mode_in;
   logic [3:0] cells_in_use_ff,  cells_in_use_in;

   assign csr_ready = 1'b1;

   always_comb begin
      ten_cell_mode_in = ten_cell_mode_ff;
      cells_in_use_in  = cells_in_use_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TEN_CELL_MODE) begin
            ten_cell_mode_in = csr_wdata[0];
         end else if (csr_index == CSR_CELLS_IN_USE) begin
            cells_in_use_in = csr_wdata[3:0];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Byte intake: frame fill, running PEC, chip counter
   // ---------------------------------------------------------------------------
   logic [4:0] byte_count_ff, byte_count_in;
   logic [7:0] running_pec_ff, running_pec_in;
   logic [3:0] chip_counter_ff, chip_counter_in;
   logic       wr_bank_ff, wr_bank_in;

   logic [4:0] frame_len;
   logic [3:0] ncells;
   logic       at_pec;      // next byte closes the frame unless it restarts the readback
   logic       req_accept;
   logic       take_data;
   logic       take_pec;
   logic [4:0] eff_count;
   logic [7:0] eff_pec;
   logic [3:0] eff_chip;
   logic [4:0] chip_next;
   logic [5:0] wr_addr;

   assign frame_len = ten_cell_mode_ff ? LEN_TEN : LEN_FULL;
   assign ncells    = ten_cell_mode_ff ? CELLS_TEN : CELLS_FULL;
   assign at_pec    = (byte_count_ff >= frame_len);

   // Emitter state (declared here for the intake interlock)
   logic       emit_active_ff, emit_active_in;
   logic [3:0] emit_cell_ff, emit_cell_in;
   logic       emit_bank_ff, emit_bank_in;
   logic [3:0] emit_chip_ff, emit_chip_in;
   logic       emit_ok_ff, emit_ok_in;

   // Hold a closing byte while the previous frame still drains
   assign req_stall  = emit_active_ff && at_pec;
   assign req_accept = req_valid && !req_stall;

   // A restart zeroes count and chip and sets the PEC to PEC_INIT before the byte is taken
   assign eff_count = req_start_of_readback ? 5'd0 : byte_count_ff;
   assign eff_pec   = req_start_of_readback ? PEC_INIT : running_pec_ff;
   assign eff_chip  = req_start_of_readback ? 4'd0 : chip_counter_ff;

   assign take_data = req_accept && (eff_count < frame_len);
   assign take_pec  = req_accept && !(eff_count < frame_len);

   assign wr_addr   = wr_bank_ff ? (6'(eff_count) + BANK_OFS) : 6'(eff_count);
   assign chip_next = {1'b0, eff_chip} + 5'd1;

   always_comb begin
      byte_count_in   = byte_count_ff;
      running_pec_in  = running_pec_ff;
      chip_counter_in = chip_counter_ff;
      wr_bank_in      = wr_bank_ff;
      if (take_data) begin
         byte_count_in   = eff_count + 5'd1;
         running_pec_in  = crc8_update(eff_pec, req_rx_byte);
         chip_counter_in = eff_chip;
      end else if (take_pec) begin
         byte_count_in   = 5'd0;
         running_pec_in  = PEC_INIT;
         chip_counter_in = (32'(chip_next) >= MAX_CHIPS) ? 4'd0 : chip_next[3:0];
         wr_bank_in      = !wr_bank_ff;   // next frame fills the other bank
      end
   end

   // ---------------------------------------------------------------------------
   // Cell emitter: one frame store read per cell, two bytes per read
   // ---------------------------------------------------------------------------
   logic          rd_valid_ff, rd_valid_in;
   cell_meta_type rd_meta_ff, rd_meta_in;
   logic          rd_advance;
   logic          issue;
   logic [2:0]    pair;
   logic [5:0]    triple_base;
   logic [5:0]    rd_addr_a;
   logic [5:0]    rd_addr_b;
   logic [7:0]    rd_data_a;
   logic [7:0]    rd_data_b;
   logic          emit_last;

   logic rsp_valid_ff, rsp_valid_in;

   assign rd_advance = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue      = emit_active_ff && (!rd_valid_ff || rd_advance);
   assign emit_last  = (emit_cell_ff == ncells - 4'd1);

   // Cell k uses bytes 3*(k/2) and up; odd cells start one byte later
   assign pair        = emit_cell_ff[3:1];
   assign triple_base = {2'b00, pair, 1'b0} + {3'b000, pair};
   assign rd_addr_a   = (emit_bank_ff ? BANK_OFS : 6'd0) + triple_base + 6'(emit_cell_ff[0]);
   assign rd_addr_b   = rd_addr_a + 6'd1;

   always_comb begin
      emit_active_in = emit_active_ff;
      emit_cell_in   = emit_cell_ff;
      emit_bank_in   = emit_bank_ff;
      emit_chip_in   = emit_chip_ff;
      emit_ok_in     = emit_ok_ff;
      if (take_pec) begin
         emit_active_in = 1'b1;
         emit_cell_in   = 4'd0;
         emit_bank_in   = wr_bank_ff;
         emit_chip_in   = eff_chip;
         emit_ok_in     = (eff_pec == req_rx_byte);
      end else if (issue) begin
         emit_cell_in = emit_cell_ff + 4'd1;
         if (emit_last) begin
            emit_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      rd_meta_in  = rd_meta_ff;
      if (issue) begin
         rd_valid_in        = 1'b1;
         rd_meta_in.chip    = emit_chip_ff;
         rd_meta_in.cell_no = emit_cell_ff;
         rd_meta_in.odd     = emit_cell_ff[0];
         rd_meta_in.ok      = emit_ok_ff;
         rd_meta_in.mv_en   = (emit_cell_ff < cells_in_use_ff);
         rd_meta_in.last    = emit_last;
      end else if (rd_advance) begin
         rd_valid_in = 1'b0;
      end
   end

   // Two copies of the frame store give two read ports
   pcvd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (take_data),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   pcvd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (take_data),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // ---------------------------------------------------------------------------
   // Unpack and convert: v = code - 512, mV = v + v/2 (toward zero)
   // ---------------------------------------------------------------------------
   logic [11:0]        code;
   logic signed [12:0] volt_ofs;
   logic signed [12:0] volt_rnd;
   logic signed [12:0] volt_half;
   logic signed [13:0] mv;

   always_comb begin
      if (!rd_meta_ff.ok) begin
         code = 12'd0;
      end else if (rd_meta_ff.odd) begin
         code = {rd_data_b, rd_data_a[7:4]};
      end else begin
         code = {rd_data_b[3:0], rd_data_a};
      end
   end

   assign volt_ofs  = $signed({1'b0, code}) - 13'sd512;
   assign volt_rnd  = volt_ofs + $signed({12'd0, volt_ofs[12]});
   assign volt_half = volt_rnd >>> 1;
   assign mv = (rd_meta_ff.ok && rd_meta_ff.mv_en)
             ? (14'(volt_ofs) + 14'(volt_half)) : 14'sd0;

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   logic [3:0]         rsp_chip_index_ff;
   logic [3:0]         rsp_cell_index_ff;
   logic [11:0]        rsp_raw_code_ff;
   logic signed [13:0] rsp_millivolts_ff;
   logic               rsp_pec_ok_ff;
   logic               rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ten_cell_mode_ff <= 1'b0;
         cells_in_use_ff  <= CELLS_IN_USE_RST;
         byte_count_ff    <= 5'd0;
         running_pec_ff   <= PEC_INIT;
         chip_counter_ff  <= 4'd0;
         wr_bank_ff       <= 1'b0;
         emit_active_ff   <= 1'b0;
         emit_cell_ff     <= 4'd0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         ten_cell_mode_ff <= ten_cell_mode_in;
         cells_in_use_ff  <= cells_in_use_in;
         byte_count_ff    <= byte_count_in;
         running_pec_ff   <= running_pec_in;
         chip_counter_ff  <= chip_counter_in;
         wr_bank_ff       <= wr_bank_in;
         emit_active_ff   <= emit_active_in;
         emit_cell_ff     <= emit_cell_in;
         rd_valid_ff      <= rd_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      emit_bank_ff <= emit_bank_in;
      emit_chip_ff <= emit_chip_in;
      emit_ok_ff   <= emit_ok_in;
      rd_meta_ff   <= rd_meta_in;
      if (rd_advance) begin
         rsp_chip_index_ff <= rd_meta_ff.chip;
         rsp_cell_index_ff <= rd_meta_ff.cell_no + 4'd1;
         rsp_raw_code_ff   <= code;
         rsp_millivolts_ff <= mv;
         rsp_pec_ok_ff     <= rd_meta_ff.ok;
         rsp_last_ff       <= rd_meta_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chip_index = rsp_chip_index_ff;
   assign rsp_cell_index = rsp_cell_index_ff;
   assign rsp_raw_code   = rsp_raw_code_ff;
   assign rsp_millivolts = rsp_millivolts_ff;
   assign rsp_pec_ok     = rsp_pec_ok_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== rtl/pcvd_checker.sv =====
// Port-level assertions for the cell voltage decoder, bound to its top level.
module pcvd_checker
   import pcvd_pkg::*;
#(
   parameter int CELLS_PER_CHIP = CELLS_PER_CHIP_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [3:0]         rsp_chip_index,
   input logic [3:0]         rsp_cell_index,
   input logic [11:0]        rsp_raw_code,
   input logic signed [13:0] rsp_millivolts,
   input logic               rsp_pec_ok,
   input logic               rsp_last
);

   // a stalled cell word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index) && $stable(rsp_raw_code)
         && $stable(rsp_millivolts) && $stable(rsp_chip_index))
      else $error("stalled cell word changed");

   // a failed check zeroes the code and the voltage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pec_ok |-> rsp_raw_code == 12'd0 && rsp_millivolts == 14'sd0)
      else $error("failed frame carries data");

   // the final word of a frame is cell 10 or the full cell count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_cell_index == 4'd10 || rsp_cell_index == 4'(CELLS_PER_CHIP))
      else $error("frame ends at wrong cell");

   // after an accepted non-final word, the next word of the frame continues the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last ##1 rsp_valid
         |-> rsp_cell_index == $past(rsp_cell_index) + 4'd1
            && rsp_chip_index == $past(rsp_chip_index))
      else $error("cell sequence broken");

endmodule

bind pec_checked_cell_voltage_decoder pcvd_checker #(
   .CELLS_PER_CHIP (CELLS_PER_CHIP)
) u_pcvd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_chip_index (rsp_chip_index),
   .rsp_cell_index (rsp_cell_index),
   .rsp_raw_code   (rsp_raw_code),
   .rsp_millivolts (rsp_millivolts),
   .rsp_pec_ok     (rsp_pec_ok),
   .rsp_last       (rsp_last)
);
